>>> rtl/rbfs_pkg.sv
// ----------------------------------------------------------------------------
// rbfs_pkg
// Shared types and constants for the ring-buffer FIFO with search.
// ----------------------------------------------------------------------------
package rbfs_pkg;

	localparam int WORD_W    = 32;
	localparam int KIND_W    = 2;
	localparam int LEN_W     = 5;
	localparam int DEPTH_DEF = 16;
	localparam int LEN_RST   = 16;

	localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} rbfs_status_t;

endpackage

>>> rtl/rbfs_ifs.sv
// ----------------------------------------------------------------------------
// rbfs_ifs
// Request, response and configuration channels (valid/ready).
// ----------------------------------------------------------------------------
interface rbfs_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface rbfs_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic [1:0]         status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink   (input valid, input result_value, input status, output ready);
endinterface

interface rbfs_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] ring_length;

	modport source (output valid, output ring_length, input ready);
	modport sink   (input valid, input ring_length, output ready);
endinterface

>>> rtl/ring_buffer_fifo_with_search_unit.sv
// ----------------------------------------------------------------------------
// ring_buffer_fifo_with_search_unit
// Ring-buffer FIFO of signed 32-bit words with push, pop and value search.
// ----------------------------------------------------------------------------
// One request is handled at a time, and every request gives one response
// beat with a status code (ok, full, empty, not found) and a word that is
// zero on failure. A push goes through the result register to the response
// register; a pop first reads one slot (registered data, no read when
// empty), and a search reads up to n entries, n being the number occupied,
// at most ring_length - 1: the single read port of the slot store streams
// one entry a cycle, and the scan stops at the first match. The request
// channel is ready again once the result sits in the response register,
// so a stalled response holds one finished result while the next request
// is taken. ring_length wraps the pointers (values below 2 act as 2, above
// DEPTH as DEPTH); usable capacity is one less. A configuration beat is
// taken at any time but only changes the length while the buffer is empty,
// and then returns both pointers to zero. The slot store has no reset and
// needs no clearing pass: only entries written by a push are ever read.
// ----------------------------------------------------------------------------
module ring_buffer_fifo_with_search_unit #(
	parameter int DEPTH = rbfs_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rbfs_req_if.sink   req,
	rbfs_rsp_if.source rsp,
	rbfs_cfg_if.sink   cfg
);
	import rbfs_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	// slot store port signals
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	// pointers, sequencer and response register
	rbfs_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg       (cfg),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// word storage, registered read data
	rbfs_mem #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

>>> rtl/rbfs_mem.sv
// ----------------------------------------------------------------------------
// rbfs_mem
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rbfs_mem #(
	parameter int DEPTH = rbfs_pkg::DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [IDX_W-1:0]           waddr,
	input  logic [rbfs_pkg::WORD_W-1:0] wdata,
	input  logic [IDX_W-1:0]           raddr,
	output logic [rbfs_pkg::WORD_W-1:0] rdata
);
	import rbfs_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/rbfs_ctrl.sv
// ----------------------------------------------------------------------------
// rbfs_ctrl
// Sequencer: head/tail pointers, push/pop/search over the slot store,
// result and output registers.
// ----------------------------------------------------------------------------
module rbfs_ctrl #(
	parameter int DEPTH = rbfs_pkg::DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rbfs_req_if.sink                    req,
	rbfs_rsp_if.source                  rsp,
	rbfs_cfg_if.sink                    cfg,
	output logic                        mem_we,
	output logic [IDX_W-1:0]            mem_waddr,
	output logic [rbfs_pkg::WORD_W-1:0] mem_wdata,
	output logic [IDX_W-1:0]            mem_raddr,
	input  logic [rbfs_pkg::WORD_W-1:0] mem_rdata
);
	import rbfs_pkg::*;

	// length compare width: holds DEPTH and any 5-bit register value
	localparam int CMP_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
	localparam int LEN_R = (DEPTH < LEN_RST) ? DEPTH : LEN_RST;

	typedef enum logic [1:0] {S_IDLE, S_POP, S_SRCH, S_RESP} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  head_q, tail_q, ptr_q;
	logic [CMP_W-1:0]  len_q;
	logic              cmp_vld_q;
	logic [WORD_W-1:0] key_q;
	logic [WORD_W-1:0] res_val_q, out_val_q;
	rbfs_status_t      res_st_q, out_st_q;
	logic              out_valid_q;

	logic              in_acc, empty, push_full, hit, out_free;
	logic [IDX_W-1:0]  tail_nxt, head_nxt, ptr_nxt;

	function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
	                                         input logic [CMP_W-1:0] len);
		logic [CMP_W-1:0] n;
		n = CMP_W'(idx) + CMP_W'(1);
		return (n >= len) ? '0 : n[IDX_W-1:0];
	endfunction

	function automatic logic [CMP_W-1:0] clamp(input logic [LEN_W-1:0] v);
		logic [CMP_W-1:0] w;
		w = CMP_W'(v);
		if (w < CMP_W'(2))
			return CMP_W'(2);
		if (w > CMP_W'(DEPTH))
			return CMP_W'(DEPTH);
		return w;
	endfunction

	assign tail_nxt  = adv(tail_q, len_q);
	assign head_nxt  = adv(head_q, len_q);
	assign ptr_nxt   = adv(ptr_q, len_q);
	assign empty     = (head_q == tail_q);
	assign push_full = (tail_nxt == head_q);
	assign in_acc    = req.valid && req.ready;
	assign hit       = cmp_vld_q && (mem_rdata == key_q);
	assign out_free  = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_val_q;
	assign rsp.status       = out_st_q;

	assign mem_we    = in_acc && (req.kind == KIND_PUSH) && !push_full;
	assign mem_waddr = tail_q;
	assign mem_wdata = req.value;
	assign mem_raddr = (state_q == S_SRCH) ? ptr_q : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			ptr_q       <= '0;
			len_q       <= CMP_W'(LEN_R);
			cmp_vld_q   <= 1'b0;
			key_q       <= '0;
			res_val_q   <= '0;
			res_st_q    <= ST_OK;
			out_val_q   <= '0;
			out_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// ring length only changes while empty; pointers restart at zero
			if (cfg.valid && cfg.ready && empty) begin
				len_q  <= clamp(cfg.ring_length);
				head_q <= '0;
				tail_q <= '0;
			end
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (req.kind)
							KIND_PUSH: begin
								if (push_full) begin
									res_val_q <= '0;
									res_st_q  <= ST_FULL;
								end else begin
									tail_q    <= tail_nxt;
									res_val_q <= req.value;
									res_st_q  <= ST_OK;
								end
								state_q <= S_RESP;
							end
							KIND_POP: begin
								if (empty) begin
									res_val_q <= '0;
									res_st_q  <= ST_EMPTY;
									state_q   <= S_RESP;
								end else begin
									state_q <= S_POP;
								end
							end
							default: begin
								// search, and the unused code too
								key_q     <= req.value;
								ptr_q     <= head_q;
								cmp_vld_q <= 1'b0;
								state_q   <= S_SRCH;
							end
						endcase
					end
				end
				S_POP: begin
					res_val_q <= mem_rdata;
					res_st_q  <= ST_OK;
					head_q    <= head_nxt;
					state_q   <= S_RESP;
				end
				S_SRCH: begin
					// issue one read a cycle, compare the previous one
					if (hit) begin
						res_val_q <= key_q;
						res_st_q  <= ST_OK;
						cmp_vld_q <= 1'b0;
						state_q   <= S_RESP;
					end else if (ptr_q == tail_q) begin
						res_val_q <= '0;
						res_st_q  <= ST_NOT_FOUND;
						cmp_vld_q <= 1'b0;
						state_q   <= S_RESP;
					end else begin
						ptr_q     <= ptr_nxt;
						cmp_vld_q <= 1'b1;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_val_q   <= res_val_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CMP_W'(head_q) < len_q) && (CMP_W'(tail_q) < len_q))
		else $error("pointer beyond ring length");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (head_q != tail_q))
		else $error("buffer empty after a successful push");

	a_pop_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> (head_q != tail_q))
		else $error("pop read issued on an empty buffer");

	a_cmp_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_q |-> (state_q == S_SRCH))
		else $error("compare pending outside search");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring-buffer FIFO with search: drives push, pop
// and search beats and ring-length writes through random sender gaps and
// receiver stalls, and checks each response beat against a local shadow of
// the slot store, the pointers and the ring length.
// ----------------------------------------------------------------------------
module tb_top;
	import rbfs_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int PTR_W = $clog2(DEPTH);

	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	// spare request code, decoded by the block as a search
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	localparam int DRAIN_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [WORD_W-1:0] word;
		rbfs_status_t             status;
	} fifo_result_t;

	logic clk = 1'b0;
	logic arst_n;

	rbfs_req_if req ();
	rbfs_rsp_if rsp ();
	rbfs_cfg_if cfg ();

	ring_buffer_fifo_with_search_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// --------------------------------------------------------------------
	// Shadow of the buffer. Updated at the edge where a request beat or a
	// ring-length beat is taken; the block serves one request at a time, in
	// order, so that is the point its own state moves on as well.
	// --------------------------------------------------------------------
	logic signed [WORD_W-1:0] slot_copy [DEPTH];
	logic [PTR_W-1:0]         head_ptr;
	logic [PTR_W-1:0]         tail_ptr;
	logic [LEN_W-1:0]         ring_len;
	logic signed [WORD_W-1:0] last_popped = '0;	// feeds stale-slot searches

	fifo_result_t expected_results [$];

	int unsigned error_count   = 0;
	int unsigned send_idle_pct = 0;	// chance per cycle of a gap before a request
	int unsigned rsp_stall_pct = 0;	// chance per cycle of ready low on rsp

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
		logic [LEN_W-1:0] n;
		n = LEN_W'(idx) + 1'b1;
		return (n >= ring_len) ? '0 : PTR_W'(n);
	endfunction

	function automatic int fill_level();
		return (int'(tail_ptr) - int'(head_ptr) + int'(ring_len)) % int'(ring_len);
	endfunction

	// Expected response for one accepted request; moves the shadow on.
	function automatic fifo_result_t fifo_predict(input logic [KIND_W-1:0] kind,
			input logic signed [WORD_W-1:0] value);
		fifo_result_t     r;
		logic [PTR_W-1:0] idx;
		r.word = '0;
		if (kind == KIND_PUSH) begin
			// one slot always left free: full when tail+1 meets head
			if (ring_next(tail_ptr) == head_ptr) begin
				r.status = ST_FULL;
			end else begin
				slot_copy[tail_ptr] = value;
				tail_ptr = ring_next(tail_ptr);
				r.word = value;
				r.status = ST_OK;
			end
		end else if (kind == KIND_POP) begin
			if (head_ptr == tail_ptr) begin
				r.status = ST_EMPTY;
			end else begin
				r.word = slot_copy[head_ptr];
				last_popped = r.word;
				head_ptr = ring_next(head_ptr);
				r.status = ST_OK;
			end
		end else begin
			// search (spare code too): only head up to tail is compared,
			// stale slots never match
			r.status = ST_NOT_FOUND;
			idx = head_ptr;
			while (idx != tail_ptr && r.status != ST_OK) begin
				if (slot_copy[idx] == value) begin
					r.word = value;
					r.status = ST_OK;
				end
				idx = ring_next(idx);
			end
		end
		return r;
	endfunction

	// Length write: dropped while anything is held, else clamped to 2..DEPTH
	// and both pointers go back to zero.
	function automatic void ring_len_write(input logic [LEN_W-1:0] v);
		if (head_ptr != tail_ptr)
			return;
		if (v < 2)
			ring_len = LEN_W'(2);
		else if (v > DEPTH)
			ring_len = LEN_W'(DEPTH);
		else
			ring_len = v;
		head_ptr = '0;
		tail_ptr = '0;
	endfunction

	// --------------------------------------------------------------------
	// Stimulus helpers
	// --------------------------------------------------------------------
	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(9))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return '1;
			4, 5: return $signed(WORD_W'($urandom_range(15))) - 32'sd8;
			default: return $urandom;
		endcase
	endfunction

	// Mostly a word that is held (hit), sometimes the last one popped
	// (its stale slot never matches), otherwise anything.
	function automatic logic signed [WORD_W-1:0] pick_search_word();
		logic [PTR_W-1:0] idx;
		int               hops;
		case ($urandom_range(4))
			0, 1, 2: begin
				if (head_ptr == tail_ptr)
					return pick_word();
				idx = head_ptr;
				hops = $urandom_range(fill_level() - 1);
				repeat (hops) idx = ring_next(idx);
				return slot_copy[idx];
			end
			3: return last_popped;
			default: return pick_word();
		endcase
	endfunction

	// One request beat. A gap lowers valid and then waits on the clock before
	// raising it, so valid never gets two assignments in the same step.
	task automatic send_request(input logic [KIND_W-1:0] kind,
			input logic signed [WORD_W-1:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req.valid <= 1'b1;
		req.kind  <= kind;
		req.value <= value;
		do @(posedge clk); while (!req.ready);
		expected_results.push_back(fifo_predict(kind, value));
	endtask

	// Ring-length beat, only once every outstanding response has come back.
	task automatic write_ring_length(input logic [LEN_W-1:0] len);
		req.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		cfg.valid       <= 1'b1;
		cfg.ring_length <= len;
		do @(posedge clk); while (!cfg.ready);
		ring_len_write(len);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain_buffer();
		while (fill_level() != 0)
			send_request(KIND_POP, $urandom);
	endtask

	// Random traffic that swings between filling up and emptying out, so
	// full pushes, empty pops and long scans all turn up.
	task automatic run_random(input int n_items);
		bit                       filling;
		int                       roll;
		logic [KIND_W-1:0]        kind;
		logic signed [WORD_W-1:0] value;
		filling = 1'b1;
		repeat (n_items) begin
			if (filling && fill_level() == int'(ring_len) - 1 && $urandom_range(3) == 0)
				filling = 1'b0;
			else if (!filling && fill_level() == 0 && $urandom_range(3) == 0)
				filling = 1'b1;
			roll = $urandom_range(99);
			if (roll < 15)
				kind = ($urandom_range(3) == 0) ? KIND_SPARE : KIND_SEARCH;
			else if (filling ? (roll < 85) : (roll >= 80))
				kind = KIND_PUSH;
			else
				kind = KIND_POP;
			if (kind == KIND_PUSH)
				value = pick_word();
			else if (kind == KIND_POP)
				value = $urandom;	// don't-care for a pop
			else
				value = pick_search_word();
			send_request(kind, value);
		end
	endtask

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------
	// Straight out of reset: nothing held.
	task automatic test_empty_requests();
		send_request(KIND_POP, 32'sd12345);
		send_request(KIND_SEARCH, '0);
		send_request(KIND_SPARE, WORD_MIN);
	endtask

	// Word extremes through the ring, hit and miss searches, a length write
	// that must be dropped because the buffer is not empty, then a search
	// for a popped word whose slot still holds it.
	task automatic test_word_extremes();
		send_request(KIND_PUSH, WORD_MIN);
		send_request(KIND_PUSH, WORD_MAX);
		send_request(KIND_PUSH, '0);
		send_request(KIND_PUSH, '1);
		send_request(KIND_SEARCH, WORD_MAX);
		send_request(KIND_SPARE, '1);
		send_request(KIND_SEARCH, 32'sd5);
		write_ring_length(LEN_W'(2));
		repeat (4) send_request(KIND_POP, $urandom);
		send_request(KIND_SEARCH, WORD_MIN);
	endtask

	// Length clamping at both ends; at the shortest ring capacity is one.
	task automatic test_length_clamp();
		write_ring_length(LEN_W'(0));
		send_request(KIND_PUSH, 32'sd7);
		send_request(KIND_PUSH, 32'sd8);
		send_request(KIND_SEARCH, 32'sd8);
		send_request(KIND_POP, $urandom);
		send_request(KIND_POP, $urandom);
		write_ring_length(LEN_W'(31));
		write_ring_length(LEN_W'(1));
		write_ring_length(LEN_W'(17));
		write_ring_length(LEN_W'(16));
	endtask

	// Eight phases, each with a length and one of four idling patterns. Some
	// phases skip the drain, so their length write can land on a busy buffer.
	task automatic test_random_traffic();
		logic [LEN_W-1:0] len;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 87;
					rsp_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rsp_stall_pct = 87;
				end
				default: begin
					send_idle_pct = 34;
					rsp_stall_pct = 34;
				end
			endcase
			case (phase)
				0: len = LEN_W'(2);
				1: len = LEN_W'(16);
				2: len = LEN_W'(0);
				3: len = LEN_W'(31);
				default: len = LEN_W'($urandom_range(31));
			endcase
			if (!(phase >= 4 && phase % 2 == 1))
				drain_buffer();
			write_ring_length(len);
			run_random(88);
		end
		drain_buffer();
	endtask

	// --------------------------------------------------------------------
	// Response side: checks each beat taken, then picks the next ready.
	// --------------------------------------------------------------------
	initial begin : response_check
		fifo_result_t want;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected response beat: result_value %0d status %0d",
						rsp.result_value, rsp.status);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.result_value !== want.word) begin
						$error("result_value: expected %0d, got %0d",
							want.word, rsp.result_value);
						error_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						error_count++;
					end
				end
			end
			rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// --------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------
	initial begin : test_sequence
		fifo_result_t left;
		int           drain_cycles;
		arst_n          <= 1'b0;
		req.valid       <= 1'b0;
		req.kind        <= KIND_PUSH;
		req.value       <= '0;
		cfg.valid       <= 1'b0;
		cfg.ring_length <= LEN_W'(LEN_RST);
		head_ptr = '0;
		tail_ptr = '0;
		ring_len = LEN_W'(LEN_RST);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_requests();
		test_word_extremes();
		test_length_clamp();
		test_random_traffic();
		req.valid <= 1'b0;

		// wait for the tail of the responses, bounded
		drain_cycles = 0;
		while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (expected_results.size() != 0) begin
			left = expected_results.pop_front();
			$error("missing response: expected result_value %0d status %0d",
				left.word, left.status);
			error_count++;
		end

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin : watchdog
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rbfs_pkg.sv
rtl/rbfs_ifs.sv
rtl/rbfs_mem.sv
rtl/rbfs_ctrl.sv
rtl/ring_buffer_fifo_with_search_unit.sv
tb/tb_top.sv
